@@ rtl/bitmap_block_allocator_macros.svh @@
// assertion macros for the bitmap block allocator
// used by modules that check their own control state
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// checked on every rising clock edge outside reset
`define BBA_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked outside reset and outside a configuration write
`define BBA_CHECK_NOCFG(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n || i_cfg_we) prop) \
        else $error(msg);

`endif

@@ rtl/bba_pkg.sv @@
// shared types and constants for the bitmap block allocator
// no dependencies
package bba_pkg;

    // bytes per block and length header bytes
    localparam int unsigned BLOCK_BYTES = 4;
    localparam int unsigned BB_SHIFT    = $clog2(BLOCK_BYTES);
    localparam int unsigned HDR_BYTES   = 4;
    localparam int unsigned NEED_W      = 15;

    // register reset value
    localparam logic [10:0] TOTAL_RESET = 11'd1024;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOSPACE  = 3'd1,
        ST_ZERO     = 3'd2,
        ST_RANGE    = 3'd3,
        ST_NOTALLOC = 3'd4
    } t_status;

    typedef enum logic {
        K_ALLOC = 1'b0,
        K_FREE  = 1'b1
    } t_kind;

    typedef struct packed {
        t_status     status;
        logic [9:0]  start_block;
        logic [10:0] run_blocks;
        logic [10:0] free_blocks;
    } t_result;

endpackage

@@ rtl/bba_ram.sv @@
// single write port, single read port memory with registered read data
// no dependencies
module bba_ram #(
    parameter int unsigned W = 1,
    parameter int unsigned D = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, old data on a same address write
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/bba_ctrl.sv @@
// sequencer of the allocator: clearing pass, next-fit scan, run marking, free walk
// depends on bba_pkg and bitmap_block_allocator_macros.svh
`include "bitmap_block_allocator_macros.svh"
module bba_ctrl
    import bba_pkg::*;
#(
    parameter int unsigned NUM_BLOCKS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_kind,
    input  logic [15:0]                   i_size_bytes,
    input  logic [9:0]                    i_block_index,
    input  logic                          i_cfg_we,
    input  logic [10:0]                   i_cfg_data,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output t_result                       o_res,
    output logic                          o_map_we,
    output logic [$clog2(NUM_BLOCKS)-1:0] o_map_waddr,
    output logic                          o_map_wdata,
    output logic [$clog2(NUM_BLOCKS)-1:0] o_map_raddr,
    input  logic                          i_map_rdata,
    output logic                          o_len_we,
    output logic [$clog2(NUM_BLOCKS)-1:0] o_len_waddr,
    output logic [$clog2(NUM_BLOCKS):0]   o_len_wdata,
    output logic [$clog2(NUM_BLOCKS)-1:0] o_len_raddr,
    input  logic [$clog2(NUM_BLOCKS):0]   i_len_rdata
);

    localparam int unsigned IW = $clog2(NUM_BLOCKS);
    localparam int unsigned CW = IW + 1;
    localparam int unsigned XW = (CW > 16) ? CW : 16;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_SCAN, S_MARK, S_FLEN, S_FREE, S_DONE
    } t_state;

    t_state         r_state, n_state;
    logic [10:0]    r_total, n_total;
    logic [IW-1:0]  r_pos, n_pos;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [CW-1:0]  r_found, n_found;
    logic [CW-1:0]  r_need, n_need;
    logic [IW-1:0]  r_start, n_start;
    logic [IW-1:0]  r_hint, n_hint;
    logic [CW-1:0]  r_free, n_free;
    t_status        r_status, n_status;
    logic [CW-1:0]  r_run, n_run;
    logic [IW-1:0]  r_ostart, n_ostart;

    logic [CW-1:0]     pool;
    logic [NEED_W-1:0] need_in;
    logic [IW-1:0]     pos_inc;
    logic [CW-1:0]     found_base;
    logic [CW-1:0]     found_new;
    logic              free_last;

    // effective pool size: register clamped to 1..NUM_BLOCKS
    function automatic logic [CW-1:0] clamp_pool(input logic [10:0] t);
        logic [XW-1:0] te;
        te = XW'(t);
        if (te == '0) begin
            return CW'(1);
        end
        if (te > XW'(NUM_BLOCKS)) begin
            return CW'(NUM_BLOCKS);
        end
        return CW'(te);
    endfunction

    assign pool    = clamp_pool(r_total);
    assign need_in = NEED_W'((17'(i_size_bytes) + 17'(HDR_BYTES + BLOCK_BYTES - 1)) >> BB_SHIFT);
    assign pos_inc = ((XW'(r_pos) + XW'(1)) == XW'(pool)) ? '0 : r_pos + IW'(1);

    // run counter of the scan; a run never crosses block zero
    assign found_base = (r_pos == '0) ? '0 : r_found;
    assign found_new  = i_map_rdata ? '0 : found_base + CW'(1);
    assign free_last  = (r_cnt == CW'(1)) || ((XW'(r_pos) + XW'(1)) == XW'(pool));

    // next state and memory port control
    always_comb begin
        n_state  = r_state;
        n_total  = r_total;
        n_pos    = r_pos;
        n_cnt    = r_cnt;
        n_found  = r_found;
        n_need   = r_need;
        n_start  = r_start;
        n_hint   = r_hint;
        n_free   = r_free;
        n_status = r_status;
        n_run    = r_run;
        n_ostart = r_ostart;
        o_map_we    = 1'b0;
        o_map_waddr = r_pos;
        o_map_wdata = 1'b0;
        o_len_we    = 1'b0;
        o_len_waddr = r_pos;
        o_len_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_map_we = 1'b1;
                o_len_we = 1'b1;
                n_pos    = r_pos + IW'(1);
                if (XW'(r_pos) == XW'(NUM_BLOCKS - 1)) begin
                    n_pos   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_run    = '0;
                    n_ostart = '0;
                    if (t_kind'(i_kind) == K_ALLOC) begin
                        if (i_size_bytes == '0) begin
                            n_status = ST_ZERO;
                            n_state  = S_DONE;
                        end else if (XW'(need_in) > XW'(pool)) begin
                            n_status = ST_NOSPACE;
                            n_state  = S_DONE;
                        end else begin
                            n_need  = CW'(need_in);
                            n_pos   = r_hint;
                            n_cnt   = '0;
                            n_found = '0;
                            n_state = S_SCAN;
                        end
                    end else begin
                        if (XW'(i_block_index) >= XW'(pool)) begin
                            n_status = ST_RANGE;
                            n_state  = S_DONE;
                        end else begin
                            n_pos   = IW'(i_block_index);
                            n_state = S_FLEN;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (found_new >= r_need) begin
                    n_start = r_pos + IW'(1) - IW'(r_need);
                    n_pos   = r_pos + IW'(1) - IW'(r_need);
                    n_cnt   = r_need;
                    n_state = S_MARK;
                end else begin
                    n_found = found_new;
                    if ((r_cnt + CW'(1)) == pool) begin
                        n_status = ST_NOSPACE;
                        n_state  = S_DONE;
                    end else begin
                        n_cnt = r_cnt + CW'(1);
                        n_pos = pos_inc;
                    end
                end
            end
            S_MARK: begin
                o_map_we    = 1'b1;
                o_map_wdata = 1'b1;
                if (r_pos == r_start) begin
                    o_len_we    = 1'b1;
                    o_len_waddr = r_start;
                    o_len_wdata = r_need;
                end
                n_pos = r_pos + IW'(1);
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_hint   = ((XW'(r_start) + XW'(r_need)) >= XW'(pool)) ? '0
                             : IW'(XW'(r_start) + XW'(r_need));
                    n_free   = r_free - r_need;
                    n_status = ST_OK;
                    n_ostart = r_start;
                    n_run    = r_need;
                    n_state  = S_DONE;
                end
            end
            S_FLEN: begin
                if (i_len_rdata == '0) begin
                    n_status = ST_NOTALLOC;
                    n_state  = S_DONE;
                end else begin
                    n_cnt   = i_len_rdata;
                    n_run   = i_len_rdata;
                    n_start = r_pos;
                    n_state = S_FREE;
                end
            end
            S_FREE: begin
                o_map_we = 1'b1;
                if (i_map_rdata) begin
                    n_free = r_free + CW'(1);
                end
                n_pos = r_pos + IW'(1);
                n_cnt = r_cnt - CW'(1);
                if (free_last) begin
                    o_len_we    = 1'b1;
                    o_len_waddr = r_start;
                    n_status    = ST_OK;
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
        // a register write restarts the pool
        if (i_cfg_we) begin
            n_total = i_cfg_data;
            n_hint  = '0;
            n_free  = clamp_pool(i_cfg_data);
            n_pos   = '0;
            n_state = S_CLEAR;
        end
    end

    // read addresses follow the next position so data lines up with r_pos
    assign o_map_raddr = n_pos;
    assign o_len_raddr = n_pos;

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_total <= TOTAL_RESET;
            r_pos   <= '0;
            r_hint  <= '0;
            r_free  <= clamp_pool(TOTAL_RESET);
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_pos   <= n_pos;
            r_hint  <= n_hint;
            r_free  <= n_free;
        end
        r_cnt    <= n_cnt;
        r_found  <= n_found;
        r_need   <= n_need;
        r_start  <= n_start;
        r_status <= n_status;
        r_run    <= n_run;
        r_ostart <= n_ostart;
    end

    assign o_ready           = (r_state == S_IDLE);
    assign o_res_valid       = (r_state == S_DONE);
    assign o_res.status      = r_status;
    assign o_res.start_block = 10'(r_ostart);
    assign o_res.run_blocks  = 11'(r_run);
    assign o_res.free_blocks = 11'(r_free);

    `BBA_CHECK(a_free_in_pool, (r_free <= pool), "free count above pool size")
    `BBA_CHECK(a_hint_in_pool, (XW'(r_hint) < XW'(pool)), "search hint outside pool")
    `BBA_CHECK(a_scan_short, ((r_state == S_SCAN) |-> (r_found < r_need)),
        "scan run reached request without grant")
    `BBA_CHECK_NOCFG(a_mark_to_done, ((r_state == S_MARK && r_cnt == CW'(1)) |=>
        (r_state == S_DONE && r_status == ST_OK)), "marking did not finish with a grant")

endmodule

@@ rtl/bitmap_block_allocator.sv @@
// top level of the bitmap block allocator: sequencer, two memories, result register
// depends on bba_pkg, bba_ram, bba_ctrl
//
// channel   direction  handshake            payload
// request   in         i_valid / o_ready    i_kind, i_size_bytes, i_block_index
// result    out        o_valid / i_ready    o_status, o_start_block, o_run_blocks, o_free_blocks
// config    in         i_cfg_we             i_cfg_data
//
// allocate: an accept step, one scan step per block looked at (up to the pool size), one
//   mark step per block marked, then the result; a rejected request goes from accept to result
// free: an accept step, a length read, one release step per block released, then the result
// reset and every config write start a clearing pass over all NUM_BLOCKS entries of both memories
// the scan position counter and the used map read port set the pace, one block a cycle
// the result register lets a waiting result stand while the sequencer goes back to idle
module bitmap_block_allocator
    import bba_pkg::*;
#(
    parameter int unsigned NUM_BLOCKS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [15:0] i_size_bytes,
    input  logic [9:0]  i_block_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [9:0]  o_start_block,
    output logic [10:0] o_run_blocks,
    output logic [10:0] o_free_blocks,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_data
);

    localparam int unsigned IW = $clog2(NUM_BLOCKS);

    logic          res_valid;
    logic          res_ready;
    t_result       res;
    logic          map_we;
    logic [IW-1:0] map_waddr;
    logic          map_wdata;
    logic [IW-1:0] map_raddr;
    logic          map_rdata;
    logic          len_we;
    logic [IW-1:0] len_waddr;
    logic [IW:0]   len_wdata;
    logic [IW-1:0] len_raddr;
    logic [IW:0]   len_rdata;

    logic          r_ovalid;
    t_result       r_out;

    bba_ctrl #(.NUM_BLOCKS(NUM_BLOCKS)) u_ctrl (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_valid                  (i_valid),
        .o_ready                  (o_ready),
        .i_kind                   (i_kind),
        .i_size_bytes             (i_size_bytes),
        .i_block_index            (i_block_index),
        .i_cfg_we                 (i_cfg_we),
        .i_cfg_data               (i_cfg_data),
        .o_res_valid              (res_valid),
        .i_res_ready              (res_ready),
        .o_res                    (res),
        .o_map_we                 (map_we),
        .o_map_waddr              (map_waddr),
        .o_map_wdata              (map_wdata),
        .o_map_raddr              (map_raddr),
        .i_map_rdata              (map_rdata),
        .o_len_we                 (len_we),
        .o_len_waddr              (len_waddr),
        .o_len_wdata              (len_wdata),
        .o_len_raddr              (len_raddr),
        .i_len_rdata              (len_rdata)
    );

    // used map, one bit per block
    bba_ram #(.W(1), .D(NUM_BLOCKS)) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    // run length store, indexed by the first block of a run
    bba_ram #(.W(IW + 1), .D(NUM_BLOCKS)) u_len (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (len_waddr),
        .i_wdata (len_wdata),
        .i_raddr (len_raddr),
        .o_rdata (len_rdata)
    );

    // result register
    assign res_ready = !r_ovalid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_status      = r_out.status;
    assign o_start_block = r_out.start_block;
    assign o_run_blocks  = r_out.run_blocks;
    assign o_free_blocks = r_out.free_blocks;

endmodule
